// ----- src/tmse_pkg.sv -----
// shared types, widths and codes of the turing machine step engine
`default_nettype none

package tmse_pkg;

    // default machine size
    localparam int DEF_STATE_COUNT  = 16;
    localparam int DEF_SYMBOL_COUNT = 8;
    localparam int DEF_TAPE_CELLS   = 1024;

    // fixed field widths
    localparam int STATE_W = 4;
    localparam int SYM_W   = 3;
    localparam int MOVE_W  = 2;
    localparam int ADDR_W  = 10;
    localparam int HEAD_OUT_W = 10;
    localparam int MASK_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK  = 1'd1;

    // head moves
    localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_RULE = 2'd0,
        CMD_WRITE_CELL = 2'd1,
        CMD_RESTART   = 2'd2,
        CMD_STEP      = 2'd3
    } cmd_t;

    // request payload, first field in the highest bits
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [MOVE_W-1:0]  move;
        logic [SYM_W-1:0]   write_symbol;
        logic [STATE_W-1:0] next_state;
        logic [SYM_W-1:0]   symbol_in;
        logic [STATE_W-1:0] state_in;
    } item_t;

    // result payload, first field in the highest bits
    typedef struct packed {
        logic                  tape_overrun;
        logic                  accepted;
        logic                  halted;
        logic [SYM_W-1:0]      symbol_under_head;
        logic [HEAD_OUT_W-1:0] head_out;
        logic [STATE_W-1:0]    state_out;
    } result_t;

    // one rule table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next_state;
        logic [SYM_W-1:0]   write_symbol;
        logic [MOVE_W-1:0]  move;
    } rule_entry_t;

    localparam int ITEM_W      = $bits(item_t);
    localparam int RESULT_W    = $bits(result_t);
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - ITEM_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

endpackage

`default_nettype wire

// ----- src/tmse_rule_ram.sv -----
// rule table memory, one write port and one registered read port
`default_nettype none

module tmse_rule_ram #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire tmse_pkg::rule_entry_t     wdata,
    input  wire logic [AW-1:0]             raddr,
    output tmse_pkg::rule_entry_t          rdata
);
    import tmse_pkg::*;

    rule_entry_t mem [DEPTH];
    rule_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/tmse_tape_ram.sv -----
// tape memory, one write port and one registered read port
`default_nettype none

module tmse_tape_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [tmse_pkg::SYM_W-1:0] wdata,
    input  wire logic [AW-1:0]              raddr,
    output logic [tmse_pkg::SYM_W-1:0]      rdata
);
    import tmse_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/tmse_core.sv -----
// sequencer: request capture, step logic, memory clear sweep and result register
`default_nettype none

module tmse_core #(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 8,
    parameter int TAPE_CELLS   = 1024,
    localparam int RULE_ENTRIES = STATE_COUNT * SYMBOL_COUNT,
    localparam int RULE_AW = $clog2(RULE_ENTRIES),
    localparam int HEAD_W  = $clog2(TAPE_CELLS)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tmse_pkg::cmd_t                in_cmd,
    input  wire tmse_pkg::item_t               in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tmse_pkg::result_t                  out_result,
    input  wire logic [tmse_pkg::STATE_W-1:0]  start_state,
    input  wire logic [tmse_pkg::MASK_W-1:0]   final_mask,
    output logic                               rule_we,
    output logic [RULE_AW-1:0]                 rule_waddr,
    output tmse_pkg::rule_entry_t              rule_wdata,
    output logic [RULE_AW-1:0]                 rule_raddr,
    input  wire tmse_pkg::rule_entry_t         rule_rdata,
    output logic                               tape_we,
    output logic [HEAD_W-1:0]                  tape_waddr,
    output logic [tmse_pkg::SYM_W-1:0]         tape_wdata,
    output logic [HEAD_W-1:0]                  tape_raddr,
    input  wire logic [tmse_pkg::SYM_W-1:0]    tape_rdata
);
    import tmse_pkg::*;

    localparam int CLR_DEPTH = (TAPE_CELLS > RULE_ENTRIES) ? TAPE_CELLS : RULE_ENTRIES;
    localparam int CNT_W = $clog2(CLR_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SETTLE,
        S_WAIT
    } fsm_t;

    fsm_t               fsm_reg;
    logic [CNT_W-1:0]   clr_cnt_reg;
    cmd_t               cmd_reg;
    item_t              item_reg;
    logic               lk_ok_reg;
    logic [STATE_W-1:0] mstate_reg, mstate_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic               halt_reg, halt_next;
    logic               overrun_reg, overrun_next;
    logic [SYM_W-1:0]   cur_sym_reg;
    logic               byp_hit_reg, byp_hit_next;
    logic [SYM_W-1:0]   byp_data_reg;
    logic               out_valid_reg;
    result_t            out_result_reg;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic [SYM_W-1:0]   cur_fwd;
    logic [SYM_W-1:0]   sym_lk;
    logic               lk_ok;
    logic               ld_ok;
    logic [RULE_AW-1:0] ld_addr;
    logic               ex_tape_we;
    logic [HEAD_W-1:0]  ex_tape_waddr;
    logic [SYM_W-1:0]   ex_tape_wdata;
    logic               ex_rule_we;
    rule_entry_t        ex_rule_wdata;
    logic               clr_last;
    result_t            result_now;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (fsm_reg == S_IDLE) || ((fsm_reg == S_SETTLE) && out_free);
    assign accept   = in_valid && in_ready;
    assign load_out = ((fsm_reg == S_SETTLE) || (fsm_reg == S_WAIT)) && out_free;
    assign clr_last = (clr_cnt_reg == CNT_W'(CLR_DEPTH - 1));

    // symbol under the head, taken from the tape read or the write just done
    assign cur_fwd = byp_hit_reg ? byp_data_reg : tape_rdata;
    assign sym_lk  = (fsm_reg == S_SETTLE) ? cur_fwd : cur_sym_reg;

    // rule lookup for the next step, issued in the accept cycle
    assign lk_ok = (32'(mstate_reg) < STATE_COUNT) && (32'(sym_lk) < SYMBOL_COUNT);
    assign rule_raddr = RULE_AW'(32'(mstate_reg) * SYMBOL_COUNT + 32'(sym_lk));

    assign ld_ok   = (32'(item_reg.state_in) < STATE_COUNT) &&
                     (32'(item_reg.symbol_in) < SYMBOL_COUNT);
    assign ld_addr = RULE_AW'(32'(item_reg.state_in) * SYMBOL_COUNT + 32'(item_reg.symbol_in));

    always_comb
    begin
        mstate_next   = mstate_reg;
        head_next     = head_reg;
        halt_next     = halt_reg;
        overrun_next  = overrun_reg;
        ex_tape_we    = 1'b0;
        ex_tape_waddr = head_reg;
        ex_tape_wdata = rule_rdata.write_symbol;
        ex_rule_we    = 1'b0;
        ex_rule_wdata = '{valid: 1'b1,
                          next_state: item_reg.next_state,
                          write_symbol: item_reg.write_symbol,
                          move: (item_reg.move == MOVE_LEFT || item_reg.move == MOVE_RIGHT)
                                ? item_reg.move : MOVE_STAY};
        if (fsm_reg == S_EXEC)
        begin
            case (cmd_reg)
                CMD_LOAD_RULE:
                begin
                    ex_rule_we = ld_ok;
                end
                CMD_WRITE_CELL:
                begin
                    ex_tape_we    = (32'(item_reg.address) < TAPE_CELLS);
                    ex_tape_waddr = HEAD_W'(item_reg.address);
                    ex_tape_wdata = item_reg.symbol_in;
                end
                CMD_RESTART:
                begin
                    head_next    = '0;
                    mstate_next  = start_state;
                    halt_next    = 1'b0;
                    overrun_next = 1'b0;
                end
                CMD_STEP:
                begin
                    if (!halt_reg)
                    begin
                        if (!(lk_ok_reg && rule_rdata.valid))
                        begin
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            mstate_next = rule_rdata.next_state;
                            ex_tape_we  = 1'b1;
                            case (rule_rdata.move)
                                MOVE_RIGHT:
                                begin
                                    // past the last cell: head stays, overrun halts
                                    if (head_reg == HEAD_W'(TAPE_CELLS - 1))
                                    begin
                                        halt_next    = 1'b1;
                                        overrun_next = 1'b1;
                                    end
                                    else
                                    begin
                                        head_next = head_reg + HEAD_W'(1);
                                    end
                                end
                                MOVE_LEFT:
                                begin
                                    if (head_reg != '0)
                                    begin
                                        head_next = head_reg - HEAD_W'(1);
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign byp_hit_next = ex_tape_we && (ex_tape_waddr == head_next);

    // memory ports, the clear sweep owns them after reset
    always_comb
    begin
        if (fsm_reg == S_CLEAR)
        begin
            tape_we    = (32'(clr_cnt_reg) < TAPE_CELLS);
            tape_waddr = HEAD_W'(clr_cnt_reg);
            tape_wdata = '0;
            rule_we    = (32'(clr_cnt_reg) < RULE_ENTRIES);
            rule_waddr = RULE_AW'(clr_cnt_reg);
            rule_wdata = '0;
        end
        else
        begin
            tape_we    = ex_tape_we;
            tape_waddr = ex_tape_waddr;
            tape_wdata = ex_tape_wdata;
            rule_we    = ex_rule_we;
            rule_waddr = ld_addr;
            rule_wdata = ex_rule_wdata;
        end
    end

    assign tape_raddr = head_next;

    always_comb
    begin
        result_now.state_out         = mstate_reg;
        result_now.head_out          = HEAD_OUT_W'(head_reg);
        result_now.symbol_under_head = (fsm_reg == S_SETTLE) ? cur_fwd : cur_sym_reg;
        result_now.halted            = halt_reg;
        result_now.accepted          = halt_reg & final_mask[mstate_reg];
        result_now.tape_overrun      = overrun_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_CLEAR;
            clr_cnt_reg   <= '0;
            mstate_reg    <= '0;
            head_reg      <= '0;
            halt_reg      <= 1'b0;
            overrun_reg   <= 1'b0;
            cur_sym_reg   <= '0;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (fsm_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CNT_W'(1);
                    if (clr_last)
                    begin
                        fsm_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fsm_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    mstate_reg  <= mstate_next;
                    head_reg    <= head_next;
                    halt_reg    <= halt_next;
                    overrun_reg <= overrun_next;
                    byp_hit_reg <= byp_hit_next;
                    fsm_reg     <= S_SETTLE;
                end
                S_SETTLE:
                begin
                    cur_sym_reg <= cur_fwd;
                    if (!out_free)
                    begin
                        fsm_reg <= S_WAIT;
                    end
                    else if (accept)
                    begin
                        fsm_reg <= S_EXEC;
                    end
                    else
                    begin
                        fsm_reg <= S_IDLE;
                    end
                end
                S_WAIT:
                begin
                    if (out_free)
                    begin
                        fsm_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    fsm_reg <= S_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            item_reg  <= in_item;
            lk_ok_reg <= lk_ok;
        end
        if (fsm_reg == S_EXEC)
        begin
            byp_data_reg <= ex_tape_wdata;
        end
        if (load_out)
        begin
            out_result_reg <= result_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

// ----- src/turing_machine_step_engine_top.sv -----
// top level of the turing machine step engine: stream ports, config registers, memories
`default_nettype none

// Single-tape Turing machine stepper driven by a request stream. Each request
// carries a command in tuser (load rule, write tape cell, restart, step) and
// its operands in tdata; each request gives exactly one result that shows the
// machine after it: state, head, symbol under the head, halted, accepted and
// tape overrun. A request issues the registered read of the rule memory as it
// is accepted, then does the rule's tape write and the registered tape read at
// the new head. The result register lets the next request in while a result
// still waits; a result not yet taken when the next one is due stalls the
// input. After reset the block clears the tape and the rule memory, one entry
// a cycle, for max(TAPE_CELLS, STATE_COUNT*SYMBOL_COUNT) entries (1024 with
// the default sizes) and keeps s_axis_tready low meanwhile; configuration
// writes are taken at any time but belong to idle periods. A reloaded rule
// replaces the earlier one. A step with no rule, or a right move past the last
// cell, halts the machine (the latter also flags overrun); only restart or
// reset clears it.
module turing_machine_step_engine_top #(
    parameter int STATE_COUNT  = tmse_pkg::DEF_STATE_COUNT,
    parameter int SYMBOL_COUNT = tmse_pkg::DEF_SYMBOL_COUNT,
    parameter int TAPE_CELLS   = tmse_pkg::DEF_TAPE_CELLS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [tmse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tmse_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // state_in, symbol_in, next_state, write_symbol, move, address
    input  wire logic [tmse_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  wire logic [1:0]                          s_axis_tuser,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // state_out, head_out, symbol_under_head, halted, accepted, tape_overrun
    output logic [tmse_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import tmse_pkg::*;

    localparam int RULE_ENTRIES = STATE_COUNT * SYMBOL_COUNT;
    localparam int RULE_AW = $clog2(RULE_ENTRIES);
    localparam int HEAD_W  = $clog2(TAPE_CELLS);

    // configuration registers
    logic [STATE_W-1:0] start_state_reg;
    logic [MASK_W-1:0]  final_mask_reg;

    // request unpacking
    item_t   in_item;
    cmd_t    in_cmd;
    result_t out_result;

    // memory ports
    logic               rule_we;
    logic [RULE_AW-1:0] rule_waddr;
    rule_entry_t        rule_wdata;
    logic [RULE_AW-1:0] rule_raddr;
    rule_entry_t        rule_rdata;
    logic               tape_we;
    logic [HEAD_W-1:0]  tape_waddr;
    logic [SYM_W-1:0]   tape_wdata;
    logic [HEAD_W-1:0]  tape_raddr;
    logic [SYM_W-1:0]   tape_rdata;

    // register writes; an index beyond the list changes nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_STATE:
                begin
                    start_state_reg <= cfg_data[STATE_W-1:0];
                end
                CFG_FINAL_MASK:
                begin
                    final_mask_reg <= cfg_data[MASK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_item = item_t'(s_axis_tdata[ITEM_W-1:0]);
    assign in_cmd  = cmd_t'(s_axis_tuser);

    tmse_core #(
        .STATE_COUNT  (STATE_COUNT),
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .TAPE_CELLS   (TAPE_CELLS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (in_cmd),
        .in_item     (in_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result),
        .start_state (start_state_reg),
        .final_mask  (final_mask_reg),
        .rule_we     (rule_we),
        .rule_waddr  (rule_waddr),
        .rule_wdata  (rule_wdata),
        .rule_raddr  (rule_raddr),
        .rule_rdata  (rule_rdata),
        .tape_we     (tape_we),
        .tape_waddr  (tape_waddr),
        .tape_wdata  (tape_wdata),
        .tape_raddr  (tape_raddr),
        .tape_rdata  (tape_rdata)
    );

    // rule table indexed by state and read symbol
    tmse_rule_ram #(
        .DEPTH (RULE_ENTRIES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (rule_waddr),
        .wdata (rule_wdata),
        .raddr (rule_raddr),
        .rdata (rule_rdata)
    );

    // tape cells
    tmse_tape_ram #(
        .DEPTH (TAPE_CELLS)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    // result packing, zero fill up to whole bytes
    assign m_axis_tdata = {OUT_PAD_W'(0), out_result};

    // accepted machines are always halted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result.accepted |-> out_result.halted)
        else $error("accepted result without halt");

    // an overrun always halts the machine
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result.tape_overrun |-> out_result.halted)
        else $error("tape overrun without halt");

    // no new request is taken in the cycle after one is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still executing");

endmodule

`default_nettype wire
